// ===== rtl/abc_pkg.sv =====
// Package for the ambient backlight controller.
// Holds the item type, the register map, the light thresholds and the divider constants.
// No dependencies.
package abc_pkg;

    // One poll tick as it travels down the pipeline.
    typedef struct packed {
        logic [15:0] display_now;
        logic [7:0]  keyboard_now;
        logic [7:0]  light_sample;
        logic [31:0] user_idle_ms;
        logic        clear_manual;
    } tick_t;

    // Configuration register indexes (word address on the APB port).
    localparam logic [2:0] REG_DISPLAY_CEILING   = 3'd0;
    localparam logic [2:0] REG_DISPLAY_FLOOR     = 3'd1;
    localparam logic [2:0] REG_KEYBOARD_CEILING  = 3'd2;
    localparam logic [2:0] REG_KEYBOARD_FLOOR    = 3'd3;
    localparam logic [2:0] REG_MANUAL_TIMEOUT_MS = 3'd4;
    localparam logic [2:0] REG_IDLE_OFF_MS       = 3'd5;
    localparam logic [2:0] REG_TICK_PERIOD_MS    = 3'd6;

    // Register reset values.
    localparam logic [15:0] DISPLAY_CEILING_RST   = 16'd1000;
    localparam logic [15:0] DISPLAY_FLOOR_RST     = 16'd10;
    localparam logic [7:0]  KEYBOARD_CEILING_RST  = 8'd255;
    localparam logic [7:0]  KEYBOARD_FLOOR_RST    = 8'd0;
    localparam logic [31:0] MANUAL_TIMEOUT_MS_RST = 32'd600000;
    localparam logic [31:0] IDLE_OFF_MS_RST       = 32'd0;
    localparam logic [15:0] TICK_PERIOD_MS_RST    = 16'd200;

    // Light sensor thresholds and the interpolation span.
    localparam logic [7:0] LIGHT_LOW  = 8'd30;
    localparam logic [7:0] LIGHT_HIGH = 8'd225;

    // Division by the span (195) as a multiply by ceil(2^32 / 195) and a shift.
    // The product of offset and level span stays below 2^24, where this is exact.
    localparam int          RECIP_SHIFT = 32;
    localparam logic [24:0] RECIP_195   = 25'd22025474;

endpackage

// ===== rtl/abc_item_if.sv =====
// Input channel of the ambient backlight controller: one poll tick per transfer.
// Valid/ready handshake with the tick fields as payload. No dependencies.
interface abc_item_if;
    logic        valid;
    logic        ready;
    logic [15:0] display_now;
    logic [7:0]  keyboard_now;
    logic [7:0]  light_sample;
    logic [31:0] user_idle_ms;
    logic        clear_manual;

    modport source (output valid, output display_now, output keyboard_now,
                    output light_sample, output user_idle_ms, output clear_manual,
                    input ready);
    modport sink   (input valid, input display_now, input keyboard_now,
                    input light_sample, input user_idle_ms, input clear_manual,
                    output ready);
endinterface

// ===== rtl/abc_result_if.sv =====
// Output channel of the ambient backlight controller: one result per transfer.
// Valid/ready handshake with the new levels and manual flags. No dependencies.
interface abc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] display_level;
    logic [7:0]  keyboard_level;
    logic        display_manual;
    logic        keyboard_manual;

    modport source (output valid, output display_level, output keyboard_level,
                    output display_manual, output keyboard_manual, input ready);
    modport sink   (input valid, input display_level, input keyboard_level,
                    input display_manual, input keyboard_manual, output ready);
endinterface

// ===== rtl/ambient_backlight_controller.sv =====
// Ambient backlight controller: every poll tick that is transferred in yields exactly one
// result with the display and keyboard levels to write and the manual-override flags. The
// block accepts one tick per clock cycle while the result side takes its results; the tick
// passes four registers before its result appears: the input register, the
// offset-times-span multiplier, the reciprocal multiplier that divides by the sensor span,
// and the output register. Override and elapsed-time state is updated only in the last
// stage, so ticks may follow each other in consecutive cycles. When the result side stalls,
// the whole pipeline holds. The first tick after reset only primes the last-level
// registers and echoes the read-back levels. Configuration goes through the APB port; the
// user must write it only while no tick is in flight, as the block does not enforce this.
module ambient_backlight_controller (
    input  logic        clk,
    input  logic        rst_n,
    abc_item_if.sink    item,
    abc_result_if.source result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [15:0] disp_ceil_reg;
    logic [15:0] disp_floor_reg;
    logic [7:0]  kbd_ceil_reg;
    logic [7:0]  kbd_floor_reg;
    logic [31:0] timeout_reg;
    logic [31:0] idle_off_reg;
    logic [15:0] tick_period_reg;

    // Pipeline registers.
    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    abc_pkg::tick_t      s1_tick_reg, s2_tick_reg, s3_tick_reg;
    logic [23:0]         s2_prod_reg;
    logic                s2_neg_reg;
    logic [15:0]         s3_quot_reg;
    logic                s3_neg_reg;

    // Tick state.
    logic        primed_reg, primed_next;
    logic [15:0] disp_last_reg, disp_last_next;
    logic [7:0]  kbd_last_reg, kbd_last_next;
    logic        disp_ov_reg, disp_ov_next;
    logic        kbd_ov_reg, kbd_ov_next;
    logic [31:0] elapsed_reg, elapsed_next;

    // Output register.
    logic        out_valid_reg;
    logic [15:0] out_disp_reg, out_disp_next;
    logic [7:0]  out_kbd_reg, out_kbd_next;
    logic        out_dman_reg, out_dman_next;
    logic        out_kman_reg, out_kman_next;

    logic        advance;
    logic        cfg_write;
    logic [2:0]  cfg_index;

    // Datapath helpers.
    logic signed [16:0] span;
    logic [15:0]        span_mag;
    logic [7:0]         light_offset;
    logic [23:0]        prod_c;
    logic [48:0]        recip_prod;
    logic [15:0]        disp_light;
    logic [7:0]         kbd_light;
    logic               timed_out;
    logic [32:0]        elapsed_sum;
    logic [31:0]        elapsed_base;

    // The pipeline moves whenever the output register is free or being emptied.
    assign advance     = !out_valid_reg || result.ready;
    assign item.ready  = advance;

    // APB port: writes land at the access phase, reads are a plain mux.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_comb
    begin
        unique case (cfg_index)
            abc_pkg::REG_DISPLAY_CEILING:   prdata = {16'd0, disp_ceil_reg};
            abc_pkg::REG_DISPLAY_FLOOR:     prdata = {16'd0, disp_floor_reg};
            abc_pkg::REG_KEYBOARD_CEILING:  prdata = {24'd0, kbd_ceil_reg};
            abc_pkg::REG_KEYBOARD_FLOOR:    prdata = {24'd0, kbd_floor_reg};
            abc_pkg::REG_MANUAL_TIMEOUT_MS: prdata = timeout_reg;
            abc_pkg::REG_IDLE_OFF_MS:       prdata = idle_off_reg;
            abc_pkg::REG_TICK_PERIOD_MS:    prdata = {16'd0, tick_period_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_ceil_reg   <= abc_pkg::DISPLAY_CEILING_RST;
            disp_floor_reg  <= abc_pkg::DISPLAY_FLOOR_RST;
            kbd_ceil_reg    <= abc_pkg::KEYBOARD_CEILING_RST;
            kbd_floor_reg   <= abc_pkg::KEYBOARD_FLOOR_RST;
            timeout_reg     <= abc_pkg::MANUAL_TIMEOUT_MS_RST;
            idle_off_reg    <= abc_pkg::IDLE_OFF_MS_RST;
            tick_period_reg <= abc_pkg::TICK_PERIOD_MS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                abc_pkg::REG_DISPLAY_CEILING:   disp_ceil_reg   <= pwdata[15:0];
                abc_pkg::REG_DISPLAY_FLOOR:     disp_floor_reg  <= pwdata[15:0];
                abc_pkg::REG_KEYBOARD_CEILING:  kbd_ceil_reg    <= pwdata[7:0];
                abc_pkg::REG_KEYBOARD_FLOOR:    kbd_floor_reg   <= pwdata[7:0];
                abc_pkg::REG_MANUAL_TIMEOUT_MS: timeout_reg     <= pwdata;
                abc_pkg::REG_IDLE_OFF_MS:       idle_off_reg    <= pwdata;
                abc_pkg::REG_TICK_PERIOD_MS:    tick_period_reg <= pwdata[15:0];
                default:                        ;
            endcase
        end
    end

    // Interpolation front end: magnitude of the level span times the light offset.
    always_comb
    begin
        span         = $signed({1'b0, disp_ceil_reg}) - $signed({1'b0, disp_floor_reg});
        span_mag     = span[16] ? 16'(-span) : span[15:0];
        light_offset = s1_tick_reg.light_sample - abc_pkg::LIGHT_LOW;
        prod_c       = 24'(light_offset) * 24'(span_mag);
    end

    // Divide by the sensor span through the reciprocal multiply.
    assign recip_prod = 49'(s2_prod_reg) * 49'(abc_pkg::RECIP_195);

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= item.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_tick_reg.display_now  <= item.display_now;
            s1_tick_reg.keyboard_now <= item.keyboard_now;
            s1_tick_reg.light_sample <= item.light_sample;
            s1_tick_reg.user_idle_ms <= item.user_idle_ms;
            s1_tick_reg.clear_manual <= item.clear_manual;
            s2_tick_reg  <= s1_tick_reg;
            s2_prod_reg  <= prod_c;
            s2_neg_reg   <= span[16];
            s3_tick_reg  <= s2_tick_reg;
            s3_quot_reg  <= recip_prod[abc_pkg::RECIP_SHIFT +: 16];
            s3_neg_reg   <= s2_neg_reg;
            out_disp_reg <= out_disp_next;
            out_kbd_reg  <= out_kbd_next;
            out_dman_reg <= out_dman_next;
            out_kman_reg <= out_kman_next;
        end
    end

    // Levels that follow the light sensor.
    always_comb
    begin
        if (s3_tick_reg.light_sample < abc_pkg::LIGHT_LOW)
        begin
            disp_light = disp_floor_reg;
            kbd_light  = kbd_floor_reg;
        end
        else if (s3_tick_reg.light_sample > abc_pkg::LIGHT_HIGH)
        begin
            disp_light = disp_ceil_reg;
            kbd_light  = kbd_ceil_reg;
        end
        else
        begin
            disp_light = s3_neg_reg ? disp_floor_reg - s3_quot_reg
                                    : disp_floor_reg + s3_quot_reg;
            kbd_light  = s3_tick_reg.light_sample;
        end
    end

    // Override tracking, level choice and elapsed time for the tick in the last stage.
    always_comb
    begin
        primed_next    = primed_reg;
        disp_last_next = disp_last_reg;
        kbd_last_next  = kbd_last_reg;
        disp_ov_next   = disp_ov_reg;
        kbd_ov_next    = kbd_ov_reg;
        elapsed_next   = elapsed_reg;
        timed_out      = elapsed_reg > timeout_reg;
        elapsed_base   = elapsed_reg;
        elapsed_sum    = 33'd0;
        out_disp_next  = out_disp_reg;
        out_kbd_next   = out_kbd_reg;
        out_dman_next  = out_dman_reg;
        out_kman_next  = out_kman_reg;

        if (s3_valid_reg && !primed_reg)
        begin
            // Priming tick: store the read-back levels and echo them.
            primed_next    = 1'b1;
            disp_last_next = s3_tick_reg.display_now;
            kbd_last_next  = s3_tick_reg.keyboard_now;
            out_disp_next  = s3_tick_reg.display_now;
            out_kbd_next   = s3_tick_reg.keyboard_now;
            out_dman_next  = 1'b0;
            out_kman_next  = 1'b0;
        end
        else if (s3_valid_reg)
        begin
            if (s3_tick_reg.clear_manual)
            begin
                disp_ov_next = 1'b0;
                kbd_ov_next  = 1'b0;
            end
            if (timed_out)
            begin
                disp_last_next = s3_tick_reg.display_now;
                kbd_last_next  = s3_tick_reg.keyboard_now;
                elapsed_base   = 32'd0;
                disp_ov_next   = 1'b0;
                kbd_ov_next    = 1'b0;
            end
            // A read-back level that moved means the user set it by hand.
            if (disp_last_next != s3_tick_reg.display_now)
            begin
                disp_last_next = s3_tick_reg.display_now;
                disp_ov_next   = 1'b1;
            end
            if (kbd_last_next != s3_tick_reg.keyboard_now)
            begin
                if (s3_tick_reg.keyboard_now != 8'd0)
                begin
                    kbd_last_next = s3_tick_reg.keyboard_now;
                end
                kbd_ov_next = 1'b1;
            end

            disp_last_next = disp_ov_next ? disp_last_next : disp_light;
            kbd_last_next  = kbd_ov_next ? kbd_last_next : kbd_light;

            out_disp_next = disp_last_next;
            out_kbd_next  = (idle_off_reg != 32'd0 && s3_tick_reg.user_idle_ms > idle_off_reg)
                            ? 8'd0 : kbd_last_next;
            out_dman_next = disp_ov_next;
            out_kman_next = kbd_ov_next;

            // Elapsed time saturates at its all-ones value.
            elapsed_sum  = {1'b0, elapsed_base} + {17'd0, tick_period_reg};
            elapsed_next = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
        end
    end

    // Tick state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            disp_last_reg <= 16'd0;
            kbd_last_reg  <= 8'd0;
            disp_ov_reg   <= 1'b0;
            kbd_ov_reg    <= 1'b0;
            elapsed_reg   <= 32'd0;
        end
        else if (advance)
        begin
            primed_reg    <= primed_next;
            disp_last_reg <= disp_last_next;
            kbd_last_reg  <= kbd_last_next;
            disp_ov_reg   <= disp_ov_next;
            kbd_ov_reg    <= kbd_ov_next;
            elapsed_reg   <= elapsed_next;
        end
    end

    // Result channel.
    assign result.valid           = out_valid_reg;
    assign result.display_level   = out_disp_reg;
    assign result.keyboard_level  = out_kbd_reg;
    assign result.display_manual  = out_dman_reg;
    assign result.keyboard_manual = out_kman_reg;

    // Once primed, the block stays primed until reset.
    a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        primed_reg |=> primed_reg)
        else $error("primed flag dropped without reset");

    // The priming result never reports a manual override.
    a_prime_no_manual: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s3_valid_reg && !primed_reg)
        |=> (!result.display_manual && !result.keyboard_manual))
        else $error("priming result flagged a manual override");

    // The flags of a regular result match the override state it left behind.
    a_flags_match_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s3_valid_reg && primed_reg)
        |=> (result.display_manual == disp_ov_reg && result.keyboard_manual == kbd_ov_reg))
        else $error("manual flags differ from override state");

    // Input back-pressure comes only from a result that waits to be taken.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (result.valid && !result.ready))
        else $error("input stalled without a pending result");

endmodule

// ===== bench/ambient_backlight_controller_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ambient backlight controller: poll ticks and APB writes
// are driven here, and a scoreboard class predicts and checks every result.
// Depends on abc_pkg, abc_item_if, abc_result_if and the controller RTL.
module ambient_backlight_controller_tb;

    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 6;
    localparam int MANUAL_RUN    = 20;
    localparam int PHASE_TICKS   = 100;
    localparam int FINAL_TICKS   = 100;

    // One result as it leaves the block.
    typedef struct packed {
        logic [15:0] display_level;
        logic [7:0]  keyboard_level;
        logic        display_manual;
        logic        keyboard_manual;
    } levels_t;

    // Scoreboard: keeps its own copy of the registers and the tick state, works out
    // the levels that each accepted tick should produce and checks results in order.
    class backlight_scoreboard;
        logic [15:0] display_ceiling;
        logic [15:0] display_floor;
        logic [7:0]  keyboard_ceiling;
        logic [7:0]  keyboard_floor;
        logic [31:0] manual_timeout_ms;
        logic [31:0] idle_off_ms;
        logic [15:0] tick_period_ms;

        bit          primed;
        logic [15:0] display_last;
        logic [7:0]  keyboard_last;
        logic [7:0]  keyboard_shown;
        bit          display_manual;
        bit          keyboard_manual;
        logic [31:0] elapsed_ms;

        levels_t     expected_levels[$];
        int          mismatches;

        function new();
            display_ceiling   = abc_pkg::DISPLAY_CEILING_RST;
            display_floor     = abc_pkg::DISPLAY_FLOOR_RST;
            keyboard_ceiling  = abc_pkg::KEYBOARD_CEILING_RST;
            keyboard_floor    = abc_pkg::KEYBOARD_FLOOR_RST;
            manual_timeout_ms = abc_pkg::MANUAL_TIMEOUT_MS_RST;
            idle_off_ms       = abc_pkg::IDLE_OFF_MS_RST;
            tick_period_ms    = abc_pkg::TICK_PERIOD_MS_RST;
            primed            = 1'b0;
            display_last      = '0;
            keyboard_last     = '0;
            keyboard_shown    = '0;
            display_manual    = 1'b0;
            keyboard_manual   = 1'b0;
            elapsed_ms        = '0;
            mismatches        = 0;
        endfunction

        task log_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        function void set_register(logic [2:0] index, logic [31:0] value);
            case (index)
                abc_pkg::REG_DISPLAY_CEILING:   display_ceiling   = value[15:0];
                abc_pkg::REG_DISPLAY_FLOOR:     display_floor     = value[15:0];
                abc_pkg::REG_KEYBOARD_CEILING:  keyboard_ceiling  = value[7:0];
                abc_pkg::REG_KEYBOARD_FLOOR:    keyboard_floor    = value[7:0];
                abc_pkg::REG_MANUAL_TIMEOUT_MS: manual_timeout_ms = value;
                abc_pkg::REG_IDLE_OFF_MS:       idle_off_ms       = value;
                abc_pkg::REG_TICK_PERIOD_MS:    tick_period_ms    = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(logic [2:0] index);
            case (index)
                abc_pkg::REG_DISPLAY_CEILING:   return {16'd0, display_ceiling};
                abc_pkg::REG_DISPLAY_FLOOR:     return {16'd0, display_floor};
                abc_pkg::REG_KEYBOARD_CEILING:  return {24'd0, keyboard_ceiling};
                abc_pkg::REG_KEYBOARD_FLOOR:    return {24'd0, keyboard_floor};
                abc_pkg::REG_MANUAL_TIMEOUT_MS: return manual_timeout_ms;
                abc_pkg::REG_IDLE_OFF_MS:       return idle_off_ms;
                abc_pkg::REG_TICK_PERIOD_MS:    return {16'd0, tick_period_ms};
                default:                        return '0;
            endcase
        endfunction

        // Linear ramp between floor and ceiling; it runs downward when the floor
        // lies above the ceiling, and the quotient truncates toward zero.
        function logic [15:0] display_for_light(logic [7:0] light);
            longint span;
            longint step;
            if (light < abc_pkg::LIGHT_LOW)
                return display_floor;
            if (light > abc_pkg::LIGHT_HIGH)
                return display_ceiling;
            span = longint'(display_ceiling) - longint'(display_floor);
            step = (longint'(light - abc_pkg::LIGHT_LOW) * span)
                   / longint'(abc_pkg::LIGHT_HIGH - abc_pkg::LIGHT_LOW);
            return 16'(step + longint'(display_floor));
        endfunction

        function logic [7:0] keyboard_for_light(logic [7:0] light);
            if (light < abc_pkg::LIGHT_LOW)
                return keyboard_floor;
            if (light > abc_pkg::LIGHT_HIGH)
                return keyboard_ceiling;
            return light;
        endfunction

        // Called once per accepted tick transfer.
        function void note_tick(abc_pkg::tick_t tick);
            levels_t     lv;
            logic [32:0] sum;
            logic [7:0]  keyboard_out;

            // The first tick after reset only primes the last levels.
            if (!primed) begin
                primed             = 1'b1;
                display_last       = tick.display_now;
                keyboard_last      = tick.keyboard_now;
                keyboard_shown     = tick.keyboard_now;
                lv.display_level   = tick.display_now;
                lv.keyboard_level  = tick.keyboard_now;
                lv.display_manual  = 1'b0;
                lv.keyboard_manual = 1'b0;
                expected_levels.push_back(lv);
                return;
            end

            if (tick.clear_manual) begin
                display_manual  = 1'b0;
                keyboard_manual = 1'b0;
            end

            // Timeout: take the read-back levels as they are and restart the count.
            if (elapsed_ms > manual_timeout_ms) begin
                display_last    = tick.display_now;
                keyboard_last   = tick.keyboard_now;
                elapsed_ms      = '0;
                display_manual  = 1'b0;
                keyboard_manual = 1'b0;
            end

            // A read-back level that moved means the user changed it by hand.
            if (display_last != tick.display_now) begin
                display_last   = tick.display_now;
                display_manual = 1'b1;
            end
            if (keyboard_last != tick.keyboard_now) begin
                if (tick.keyboard_now != 8'd0)
                    keyboard_last = tick.keyboard_now;
                keyboard_manual = 1'b1;
            end

            display_last  = display_manual ? display_last
                                           : display_for_light(tick.light_sample);
            keyboard_last = keyboard_manual ? keyboard_last
                                            : keyboard_for_light(tick.light_sample);

            // An idle user turns the keyboard dark without touching the last level.
            keyboard_out = keyboard_last;
            if (idle_off_ms != 32'd0 && tick.user_idle_ms > idle_off_ms)
                keyboard_out = 8'd0;
            keyboard_shown = keyboard_out;

            sum        = {1'b0, elapsed_ms} + {17'd0, tick_period_ms};
            elapsed_ms = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

            lv.display_level   = display_last;
            lv.keyboard_level  = keyboard_out;
            lv.display_manual  = display_manual;
            lv.keyboard_manual = keyboard_manual;
            expected_levels.push_back(lv);
        endfunction

        // Called once per accepted result transfer.
        task check_levels(levels_t got);
            levels_t want;
            if (expected_levels.size() == 0) begin
                log_mismatch($sformatf("unexpected result display %0d keyboard %0d",
                                       got.display_level, got.keyboard_level));
                return;
            end
            want = expected_levels.pop_front();
            if (got.display_level !== want.display_level)
                log_mismatch($sformatf("display_level %0d, expected %0d",
                                       got.display_level, want.display_level));
            if (got.keyboard_level !== want.keyboard_level)
                log_mismatch($sformatf("keyboard_level %0d, expected %0d",
                                       got.keyboard_level, want.keyboard_level));
            if (got.display_manual !== want.display_manual)
                log_mismatch($sformatf("display_manual %b, expected %b",
                                       got.display_manual, want.display_manual));
            if (got.keyboard_manual !== want.keyboard_manual)
                log_mismatch($sformatf("keyboard_manual %b, expected %b",
                                       got.keyboard_manual, want.keyboard_manual));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          gap_pct;
    int          stall_pct;
    int          quiet_cycles;

    backlight_scoreboard sb = new();

    abc_item_if   item_bus ();
    abc_result_if result_bus ();

    ambient_backlight_controller uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // APB write of one register, then a read of it to confirm the stored value.
    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(index, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== sb.register_value(index))
            sb.log_mismatch($sformatf("register %0d reads %h, expected %h",
                                      index, prdata, sb.register_value(index)));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one tick and hold it until the block takes it.
    task automatic send_tick(input abc_pkg::tick_t tick);
        item_bus.valid        <= 1'b1;
        item_bus.display_now  <= tick.display_now;
        item_bus.keyboard_now <= tick.keyboard_now;
        item_bus.light_sample <= tick.light_sample;
        item_bus.user_idle_ms <= tick.user_idle_ms;
        item_bus.clear_manual <= tick.clear_manual;
        do @(posedge clk); while (!item_bus.ready);
        sb.note_tick(tick);
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic settle_block();
        item_bus.valid <= 1'b0;
        while (sb.expected_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A tick whose read-back levels match what the block last wrote.
    function automatic abc_pkg::tick_t steady_tick(logic [7:0] light, logic [31:0] idle_ms);
        abc_pkg::tick_t tick;
        tick.display_now  = sb.display_last;
        tick.keyboard_now = sb.keyboard_last;
        tick.light_sample = light;
        tick.user_idle_ms = idle_ms;
        tick.clear_manual = 1'b0;
        return tick;
    endfunction

    // Result side: ready drops in random bursts while stall_pct is nonzero.
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
        end
    end

    // Every result transfer is checked against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            sb.check_levels({result_bus.display_level, result_bus.keyboard_level,
                             result_bus.display_manual, result_bus.keyboard_manual});
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if (rst_n !== 1'b1 || psel === 1'b1
                || (item_bus.valid === 1'b1 && item_bus.ready === 1'b1)
                || (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        abc_pkg::tick_t tick;
        logic [7:0]  sweep [9];
        logic [7:0]  light;
        logic [31:0] idle_ms;
        int          n;
        int          phase;
        int          count;
        int unsigned roll;

        sweep = '{8'd0, abc_pkg::LIGHT_LOW - 8'd1, abc_pkg::LIGHT_LOW,
                  abc_pkg::LIGHT_LOW + 8'd1, 8'd128, abc_pkg::LIGHT_HIGH - 8'd1,
                  abc_pkg::LIGHT_HIGH, abc_pkg::LIGHT_HIGH + 8'd1, 8'd255};

        // Known values on every input from the start.
        rst_n                 <= 1'b0;
        item_bus.valid        <= 1'b0;
        item_bus.display_now  <= '0;
        item_bus.keyboard_now <= '0;
        item_bus.light_sample <= '0;
        item_bus.user_idle_ms <= '0;
        item_bus.clear_manual <= 1'b0;
        result_bus.ready      <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        gap_pct                = 0;
        stall_pct              = 10;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: priming tick, light sweep across both thresholds.
        tick = steady_tick(8'd0, 32'hFFFF_FFFF);
        tick.display_now  = 16'hFFFF;
        tick.keyboard_now = 8'hFF;
        tick.clear_manual = 1'b1;
        send_tick(tick);
        for (n = 0; n < 9; n++)
            send_tick(steady_tick(sweep[n], 32'hFFFF_FFFF));

        // Manual changes by the user, a zero keyboard read-back, and clearing.
        tick = steady_tick(8'd128, 32'd0);
        tick.display_now = 16'h1234;
        send_tick(tick);
        tick = steady_tick(8'd128, 32'd0);
        tick.keyboard_now = 8'd0;
        send_tick(tick);
        tick = steady_tick(8'd200, 32'd0);
        tick.keyboard_now = 8'h80;
        send_tick(tick);
        send_tick(steady_tick(8'd200, 32'd0));
        tick = steady_tick(8'd10, 32'd0);
        tick.clear_manual = 1'b1;
        send_tick(tick);
        tick = steady_tick(8'd240, 32'd0);
        tick.display_now  = 16'h0000;
        tick.clear_manual = 1'b1;
        send_tick(tick);

        // Floor above ceiling, zero timeout, idle cutoff and a zero tick period.
        settle_block();
        write_register(abc_pkg::REG_DISPLAY_CEILING, 32'd0);
        write_register(abc_pkg::REG_DISPLAY_FLOOR, 32'd65535);
        write_register(abc_pkg::REG_KEYBOARD_CEILING, 32'd0);
        write_register(abc_pkg::REG_KEYBOARD_FLOOR, 32'd255);
        write_register(abc_pkg::REG_MANUAL_TIMEOUT_MS, 32'd0);
        write_register(abc_pkg::REG_IDLE_OFF_MS, 32'd1000);
        write_register(abc_pkg::REG_TICK_PERIOD_MS, 32'd0);
        for (n = 0; n < 9; n++)
            send_tick(steady_tick(sweep[n], (n == 8) ? 32'hFFFF_FFFF : 32'd1000 + (n % 2)));

        // Timeout at its maximum: the elapsed count never passes it, so the
        // display stays manual until the clear event.
        settle_block();
        write_register(abc_pkg::REG_DISPLAY_CEILING, 32'd65535);
        write_register(abc_pkg::REG_DISPLAY_FLOOR, 32'd0);
        write_register(abc_pkg::REG_KEYBOARD_CEILING, 32'd255);
        write_register(abc_pkg::REG_KEYBOARD_FLOOR, 32'd0);
        write_register(abc_pkg::REG_MANUAL_TIMEOUT_MS, 32'hFFFF_FFFF);
        write_register(abc_pkg::REG_IDLE_OFF_MS, 32'hFFFF_FFFF);
        write_register(abc_pkg::REG_TICK_PERIOD_MS, 32'd65535);
        stall_pct = 0;
        tick = steady_tick(8'd100, 32'hFFFF_FFFF);
        tick.display_now = sb.display_last ^ 16'h00FF;
        send_tick(tick);
        for (n = 0; n < MANUAL_RUN; n++)
            send_tick(steady_tick(8'($urandom_range(0, 255)), $urandom));
        tick = steady_tick(8'd100, 32'd0);
        tick.clear_manual = 1'b1;
        send_tick(tick);

        // Random phases, each with fresh register settings; the last one runs
        // without idling on either side.
        for (phase = 0; phase < 6; phase++) begin
            settle_block();
            write_register(abc_pkg::REG_DISPLAY_CEILING, $urandom_range(0, 65535));
            write_register(abc_pkg::REG_DISPLAY_FLOOR, ($urandom_range(0, 3) == 0)
                           ? $urandom_range(0, 65535) : $urandom_range(0, sb.display_ceiling));
            write_register(abc_pkg::REG_KEYBOARD_CEILING, $urandom_range(0, 255));
            write_register(abc_pkg::REG_KEYBOARD_FLOOR, ($urandom_range(0, 3) == 0)
                           ? $urandom_range(0, 255) : $urandom_range(0, sb.keyboard_ceiling));
            case ($urandom_range(0, 3))
                0:       write_register(abc_pkg::REG_MANUAL_TIMEOUT_MS,
                                        $urandom_range(0, 2000));
                1:       write_register(abc_pkg::REG_MANUAL_TIMEOUT_MS,
                                        $urandom_range(0, 100000));
                2:       write_register(abc_pkg::REG_MANUAL_TIMEOUT_MS, 32'hFFFF_FFFF);
                default: write_register(abc_pkg::REG_MANUAL_TIMEOUT_MS, $urandom);
            endcase
            case ($urandom_range(0, 2))
                0:       write_register(abc_pkg::REG_IDLE_OFF_MS, 32'd0);
                1:       write_register(abc_pkg::REG_IDLE_OFF_MS, $urandom_range(1, 5000));
                default: write_register(abc_pkg::REG_IDLE_OFF_MS, $urandom);
            endcase
            write_register(abc_pkg::REG_TICK_PERIOD_MS, ($urandom_range(0, 1) == 0)
                           ? $urandom_range(1, 500) : $urandom_range(1, 65535));

            if (phase == 5) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = (phase == 1) ? 0 : $urandom_range(5, 30);
                stall_pct = (phase == 2) ? 0 : $urandom_range(3, 20);
            end

            count = (phase == 5) ? FINAL_TICKS : PHASE_TICKS;
            for (n = 0; n < count; n++) begin
                case ($urandom_range(0, 9))
                    0:       light = 8'd0;
                    1:       light = abc_pkg::LIGHT_LOW - 8'd1;
                    2:       light = abc_pkg::LIGHT_LOW;
                    3:       light = abc_pkg::LIGHT_HIGH;
                    4:       light = abc_pkg::LIGHT_HIGH + 8'd1;
                    5:       light = 8'd255;
                    default: light = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 4))
                    0:       idle_ms = 32'd0;
                    1:       idle_ms = sb.idle_off_ms;
                    2:       idle_ms = sb.idle_off_ms + 32'd1;
                    3:       idle_ms = 32'hFFFF_FFFF;
                    default: idle_ms = $urandom;
                endcase

                // Mostly well-formed read-backs, some user changes, some noise.
                tick = steady_tick(light, idle_ms);
                roll = $urandom_range(0, 99);
                if (roll < 10)
                    tick.display_now = 16'($urandom);
                else if (roll < 20)
                    tick.keyboard_now = 8'($urandom);
                else if (roll < 35)
                    tick.keyboard_now = sb.keyboard_shown;
                else if (roll < 43) begin
                    tick.display_now  = 16'($urandom);
                    tick.keyboard_now = 8'($urandom);
                end
                tick.clear_manual = ($urandom_range(0, 9) == 0);
                send_tick(tick);

                if (phase != 5 && $urandom_range(0, 49) == 0)
                    settle_block();
                else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                    item_bus.valid <= 1'b0;
                    repeat ($urandom_range(1, 17)) @(posedge clk);
                end
            end
        end

        settle_block();
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
